[rtl/core/grid_maze_dfs_solver_macros.svh]
// assertion macros shared by the maze solver rtl
`ifndef GRID_MAZE_DFS_SOLVER_MACROS_SVH
`define GRID_MAZE_DFS_SOLVER_MACROS_SVH

// same-cycle implication, disabled in reset
`define GMDS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define GMDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/gmds_pkg.sv]
// shared types, constants and helpers of the maze solver
package gmds_pkg;

   localparam int MAX_COLS = 32;
   localparam int MAX_ROWS = 32;
   localparam int MIN_GRID = 2;
   localparam int CELLS    = MAX_COLS * MAX_ROWS;
   localparam int COORD_W  = 5;
   localparam int CELL_AW  = 2 * COORD_W;
   localparam int DEPTH_W  = 11;
   localparam int GRID_W   = 6;
   localparam int WALL_W   = 4;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_START   = 2'd1,
      OP_ADVANCE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      EV_LOADED    = 3'd0,
      EV_VISITED   = 3'd1,
      EV_ABANDONED = 3'd2,
      EV_GOAL      = 3'd3,
      EV_NOPATH    = 3'd4,
      EV_IDLE      = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SEARCH = 2'd1,
      ST_GOAL   = 2'd2,
      ST_FAIL   = 2'd3
   } status_type;

   // neighbour order; the code is also the wall bit index
   typedef enum logic [1:0] {
      DIR_N = 2'd0,
      DIR_E = 2'd1,
      DIR_S = 2'd2,
      DIR_W = 2'd3
   } dir_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_PUSH,
      S_TOP_GOAL,
      S_TOP,
      S_WALL,
      S_NEIGH,
      S_VIS,
      S_OUT
   } state_type;

   typedef struct packed {
      logic                wall_we;
      logic [CELL_AW-1:0]  wall_addr;
      logic [WALL_W-1:0]   wall_wdata;
      logic                vis_we;
      logic [CELL_AW-1:0]  vis_addr;
      logic                vis_wdata;
   } cell_req_type;

   typedef struct packed {
      logic                we;
      logic [CELL_AW-1:0]  addr;
      logic [CELL_AW-1:0]  wdata;
   } stack_req_type;

   typedef struct packed {
      event_type           ev;
      logic [COORD_W-1:0]  col;
      logic [COORD_W-1:0]  row;
      logic [DEPTH_W-1:0]  depth;
   } result_type;

   // clamp a grid size register into MIN_GRID..max_val
   function automatic logic [GRID_W-1:0] clamp_grid(input logic [GRID_W-1:0] v,
                                                    input logic [GRID_W-1:0] max_val);
      logic [GRID_W-1:0] r;
      r = v;
      if (v < GRID_W'(MIN_GRID)) begin
         r = GRID_W'(MIN_GRID);
      end else if (v > max_val) begin
         r = max_val;
      end
      return r;
   endfunction

endpackage

[rtl/core/gmds_cell_mem.sv]
// wall map and visited map memories, registered reads
module gmds_cell_mem (
   input  logic                      clock,
   input  gmds_pkg::cell_req_type    cell_req,
   output logic [gmds_pkg::WALL_W-1:0] wall_rdata,
   output logic                      vis_rdata
);
   import gmds_pkg::*;

   logic [WALL_W-1:0] wall_mem [CELLS];
   logic              vis_mem  [CELLS];

   // wall map port
   always_ff @(posedge clock) begin
      if (cell_req.wall_we) begin
         wall_mem[cell_req.wall_addr] <= cell_req.wall_wdata;
      end
      wall_rdata <= wall_mem[cell_req.wall_addr];
   end

   // visited map port
   always_ff @(posedge clock) begin
      if (cell_req.vis_we) begin
         vis_mem[cell_req.vis_addr] <= cell_req.vis_wdata;
      end
      vis_rdata <= vis_mem[cell_req.vis_addr];
   end

endmodule

[rtl/core/gmds_stack_mem.sv]
// path stack memory, packed {row, col} per entry
module gmds_stack_mem (
   input  logic                         clock,
   input  gmds_pkg::stack_req_type      stack_req,
   output logic [gmds_pkg::CELL_AW-1:0] stack_rdata
);
   import gmds_pkg::*;

   logic [CELL_AW-1:0] stack_mem [CELLS];

   // single port, registered read data
   always_ff @(posedge clock) begin
      if (stack_req.we) begin
         stack_mem[stack_req.addr] <= stack_req.wdata;
      end
      stack_rdata <= stack_mem[stack_req.addr];
   end

endmodule

[rtl/core/gmds_ctrl.sv]
// search sequencer: decodes items, walks neighbours, drives the memories
module gmds_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_operation,
   input  logic [gmds_pkg::COORD_W-1:0]  req_cell_col,
   input  logic [gmds_pkg::COORD_W-1:0]  req_cell_row,
   input  logic                          req_wall_north,
   input  logic                          req_wall_east,
   input  logic                          req_wall_south,
   input  logic                          req_wall_west,
   input  logic [gmds_pkg::GRID_W-1:0]   grid_cols,
   input  logic [gmds_pkg::GRID_W-1:0]   grid_rows,
   output gmds_pkg::cell_req_type        cell_req,
   input  logic [gmds_pkg::WALL_W-1:0]   wall_rdata,
   input  logic                          vis_rdata,
   output gmds_pkg::stack_req_type       stack_req,
   input  logic [gmds_pkg::CELL_AW-1:0]  stack_rdata,
   input  logic                          out_free,
   output logic                          res_valid,
   output gmds_pkg::result_type          res
);
   import gmds_pkg::*;

   state_type           state_ff, state_in;
   status_type          status_ff, status_in;
   logic [DEPTH_W-1:0]  sp_ff, sp_in;
   logic [CELL_AW-1:0]  clr_ff, clr_in;
   logic [COORD_W-1:0]  cur_col_ff, cur_col_in;
   logic [COORD_W-1:0]  cur_row_ff, cur_row_in;
   logic [WALL_W-1:0]   walls_ff, walls_in;
   dir_type             dir_ff, dir_in;
   logic [COORD_W-1:0]  nb_col_ff, nb_col_in;
   logic [COORD_W-1:0]  nb_row_ff, nb_row_in;
   result_type          res_ff, res_in;

   logic [GRID_W-1:0]   cols_eff;
   logic [GRID_W-1:0]   rows_eff;
   logic [GRID_W-1:0]   goal_col;
   logic [GRID_W-1:0]   goal_row;
   logic [DEPTH_W-1:0]  sp_dec;
   logic [COORD_W-1:0]  cand_col;
   logic [COORD_W-1:0]  cand_row;
   logic                cand_inside;
   logic                cand_ok;
   logic                nb_goal;

   // grid size and goal cell from the current registers
   assign cols_eff = clamp_grid(grid_cols, GRID_W'(MAX_COLS));
   assign rows_eff = clamp_grid(grid_rows, GRID_W'(MAX_ROWS));
   assign goal_col = {1'b0, cols_eff[GRID_W-1:1]} - GRID_W'(1);
   assign goal_row = {1'b0, rows_eff[GRID_W-1:1]} - GRID_W'(1);
   assign nb_goal  = ({1'b0, nb_col_ff} == goal_col) && ({1'b0, nb_row_ff} == goal_row);
   assign sp_dec   = sp_ff - DEPTH_W'(1);

   // candidate neighbour of the top cell in the current direction
   always_comb begin
      cand_col    = cur_col_ff;
      cand_row    = cur_row_ff;
      cand_inside = 1'b0;
      case (dir_ff)
         DIR_N: begin
            cand_row    = cur_row_ff + COORD_W'(1);
            cand_inside = ({1'b0, cur_row_ff} + GRID_W'(1)) < rows_eff;
         end
         DIR_E: begin
            cand_col    = cur_col_ff + COORD_W'(1);
            cand_inside = ({1'b0, cur_col_ff} + GRID_W'(1)) < cols_eff;
         end
         DIR_S: begin
            cand_row    = cur_row_ff - COORD_W'(1);
            cand_inside = (cur_row_ff != '0);
         end
         DIR_W: begin
            cand_col    = cur_col_ff - COORD_W'(1);
            cand_inside = (cur_col_ff != '0);
         end
         default: begin
            cand_inside = 1'b0;
         end
      endcase
      cand_ok = cand_inside && !walls_ff[dir_ff];
   end

   // state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_IDLE;
         sp_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         sp_ff     <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      clr_ff     <= clr_in;
      cur_col_ff <= cur_col_in;
      cur_row_ff <= cur_row_in;
      walls_ff   <= walls_in;
      dir_ff     <= dir_in;
      nb_col_ff  <= nb_col_in;
      nb_row_ff  <= nb_row_in;
      res_ff     <= res_in;
   end

   // next state and memory requests
   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      sp_in      = sp_ff;
      clr_in     = clr_ff;
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      walls_in   = walls_ff;
      dir_in     = dir_ff;
      nb_col_in  = nb_col_ff;
      nb_row_in  = nb_row_ff;
      res_in     = res_ff;
      req_ready  = 1'b0;
      res_valid  = 1'b0;

      cell_req            = '0;
      cell_req.wall_addr  = {cur_row_ff, cur_col_ff};
      cell_req.vis_addr   = {nb_row_ff, nb_col_ff};
      stack_req           = '0;
      stack_req.addr      = sp_dec[CELL_AW-1:0];

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_operation)
                  OP_LOAD: begin
                     cell_req.wall_we    = 1'b1;
                     cell_req.wall_addr  = {req_cell_row, req_cell_col};
                     cell_req.wall_wdata = {req_wall_west, req_wall_south,
                                            req_wall_east, req_wall_north};
                     res_in   = '{EV_LOADED, req_cell_col, req_cell_row, sp_ff};
                     state_in = S_OUT;
                  end
                  OP_START: begin
                     sp_in     = '0;
                     status_in = ST_SEARCH;
                     clr_in    = '0;
                     nb_col_in = '0;
                     nb_row_in = '0;
                     state_in  = S_CLEAR;
                  end
                  OP_ADVANCE: begin
                     case (status_ff)
                        ST_IDLE: begin
                           res_in   = '{EV_IDLE, '0, '0, sp_ff};
                           state_in = S_OUT;
                        end
                        ST_GOAL: begin
                           state_in = S_TOP_GOAL;
                        end
                        ST_SEARCH: begin
                           if (sp_ff == '0) begin
                              status_in = ST_FAIL;
                              res_in    = '{EV_NOPATH, '0, '0, sp_ff};
                              state_in  = S_OUT;
                           end else begin
                              state_in = S_TOP;
                           end
                        end
                        default: begin
                           status_in = ST_FAIL;
                           res_in    = '{EV_NOPATH, '0, '0, sp_ff};
                           state_in  = S_OUT;
                        end
                     endcase
                  end
                  default: begin
                     res_in   = '{EV_IDLE, '0, '0, sp_ff};
                     state_in = S_OUT;
                  end
               endcase
            end
         end

         // sweep the visited map to zero, one entry a cycle
         S_CLEAR: begin
            cell_req.vis_we    = 1'b1;
            cell_req.vis_addr  = clr_ff;
            cell_req.vis_wdata = 1'b0;
            clr_in             = clr_ff + CELL_AW'(1);
            if (clr_ff == CELL_AW'(CELLS - 1)) begin
               state_in = S_PUSH;
            end
         end

         // push the pending cell and mark it visited
         S_PUSH: begin
            if (sp_ff < DEPTH_W'(CELLS)) begin
               stack_req.we    = 1'b1;
               stack_req.addr  = sp_ff[CELL_AW-1:0];
               stack_req.wdata = {nb_row_ff, nb_col_ff};
               sp_in           = sp_ff + DEPTH_W'(1);
            end
            cell_req.vis_we    = 1'b1;
            cell_req.vis_wdata = 1'b1;
            if (nb_goal) begin
               status_in = ST_GOAL;
               res_in    = '{EV_GOAL, nb_col_ff, nb_row_ff, sp_in};
            end else begin
               res_in    = '{EV_VISITED, nb_col_ff, nb_row_ff, sp_in};
            end
            state_in = S_OUT;
         end

         // goal already found: report the top cell again
         S_TOP_GOAL: begin
            res_in   = '{EV_GOAL, stack_rdata[COORD_W-1:0],
                         stack_rdata[CELL_AW-1:COORD_W], sp_ff};
            state_in = S_OUT;
         end

         // top cell arrives, fetch its walls
         S_TOP: begin
            cur_col_in         = stack_rdata[COORD_W-1:0];
            cur_row_in         = stack_rdata[CELL_AW-1:COORD_W];
            cell_req.wall_addr = stack_rdata;
            state_in           = S_WALL;
         end

         S_WALL: begin
            walls_in = wall_rdata;
            dir_in   = DIR_N;
            state_in = S_NEIGH;
         end

         // skip walled or outside directions, else fetch the visited bit; pop after west
         S_NEIGH: begin
            if (cand_ok) begin
               cell_req.vis_addr = {cand_row, cand_col};
               nb_col_in         = cand_col;
               nb_row_in         = cand_row;
               state_in          = S_VIS;
            end else if (dir_ff == DIR_W) begin
               sp_in    = sp_dec;
               res_in   = '{EV_ABANDONED, cur_col_ff, cur_row_ff, sp_dec};
               state_in = S_OUT;
            end else begin
               dir_in = dir_type'(dir_ff + 2'd1);
            end
         end

         // unvisited neighbour is taken, otherwise next direction or pop
         S_VIS: begin
            if (!vis_rdata) begin
               state_in = S_PUSH;
            end else if (dir_ff == DIR_W) begin
               sp_in    = sp_dec;
               res_in   = '{EV_ABANDONED, cur_col_ff, cur_row_ff, sp_dec};
               state_in = S_OUT;
            end else begin
               dir_in   = dir_type'(dir_ff + 2'd1);
               state_in = S_NEIGH;
            end
         end

         // hand the item to the output register once it is free
         S_OUT: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res = res_ff;

endmodule

[rtl/core/grid_maze_dfs_solver.sv]
// Depth-first grid maze solver, one search step per item.
// Load, idle and no-path advance items go straight to S_OUT; a goal repeat reads the stack
// top; a search step reads the top cell, its walls, the visited bit of each open direction,
// then pushes or pops; a start clears the 1024-entry visited map one entry a cycle, then pushes.
// One item in work; req_ready is back as rsp_valid rises; an unread result stalls S_OUT.
// Reset (synchronous): grid 32 x 32, search idle, stack empty; walls and stack undefined.
module grid_maze_dfs_solver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_operation,
   input  logic [gmds_pkg::COORD_W-1:0]  req_cell_col,
   input  logic [gmds_pkg::COORD_W-1:0]  req_cell_row,
   input  logic                          req_wall_north,
   input  logic                          req_wall_east,
   input  logic                          req_wall_south,
   input  logic                          req_wall_west,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_event_res,
   output logic [gmds_pkg::COORD_W-1:0]  rsp_event_col,
   output logic [gmds_pkg::COORD_W-1:0]  rsp_event_row,
   output logic [gmds_pkg::DEPTH_W-1:0]  rsp_stack_depth,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [gmds_pkg::GRID_W-1:0]   csr_wdata
);
   import gmds_pkg::*;

`include "grid_maze_dfs_solver_macros.svh"

   logic [GRID_W-1:0]   grid_cols_ff;
   logic [GRID_W-1:0]   grid_rows_ff;
   logic                rsp_valid_ff;
   result_type          rsp_data_ff;
   cell_req_type        cell_req;
   stack_req_type       stack_req;
   logic [WALL_W-1:0]   wall_rdata;
   logic                vis_rdata;
   logic [CELL_AW-1:0]  stack_rdata;
   logic                out_free;
   logic                res_valid;
   result_type          res;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= GRID_W'(MAX_COLS);
         grid_rows_ff <= GRID_W'(MAX_ROWS);
      end else if (csr_valid) begin
         if (csr_index == 1'b0) begin
            grid_cols_ff <= csr_wdata;
         end else begin
            grid_rows_ff <= csr_wdata;
         end
      end
   end

   gmds_cell_mem u_cell_mem (
      .clock      (clock),
      .cell_req   (cell_req),
      .wall_rdata (wall_rdata),
      .vis_rdata  (vis_rdata)
   );

   gmds_stack_mem u_stack_mem (
      .clock       (clock),
      .stack_req   (stack_req),
      .stack_rdata (stack_rdata)
   );

   gmds_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_cell_col   (req_cell_col),
      .req_cell_row   (req_cell_row),
      .req_wall_north (req_wall_north),
      .req_wall_east  (req_wall_east),
      .req_wall_south (req_wall_south),
      .req_wall_west  (req_wall_west),
      .grid_cols      (grid_cols_ff),
      .grid_rows      (grid_rows_ff),
      .cell_req       (cell_req),
      .wall_rdata     (wall_rdata),
      .vis_rdata      (vis_rdata),
      .stack_req      (stack_req),
      .stack_rdata    (stack_rdata),
      .out_free       (out_free),
      .res_valid      (res_valid),
      .res            (res)
   );

   // output register between the sequencer and the result channel
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = rsp_data_ff.ev;
   assign rsp_event_col   = rsp_data_ff.col;
   assign rsp_event_row   = rsp_data_ff.row;
   assign rsp_stack_depth = rsp_data_ff.depth;

   // checks
   `GMDS_ASSERT_NEXT(a_one_item_in_work, clock, reset, req_valid && req_ready, !req_ready, "item accepted while another is in work")
   `GMDS_ASSERT_IMPL(a_depth_bound, clock, reset, rsp_valid, rsp_stack_depth <= DEPTH_W'(CELLS), "reported depth beyond the stack size")
   `GMDS_ASSERT_IMPL(a_nopath_cell, clock, reset, rsp_valid && rsp_event_res == EV_NOPATH, rsp_event_col == '0 && rsp_event_row == '0, "no path reported with a cell")
   `GMDS_ASSERT_IMPL(a_idle_cell, clock, reset, rsp_valid && rsp_event_res == EV_IDLE, rsp_event_col == '0 && rsp_event_row == '0, "idle reported with a cell")

endmodule

[verif/tb_top.sv]
// self-checking testbench of the depth-first grid maze solver
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gmds_pkg::*;

   localparam logic [1:0] OP_UNKNOWN    = 2'd3;
   localparam logic       REG_GRID_COLS = 1'b0;
   localparam logic       REG_GRID_ROWS = 1'b1;
   localparam int         STALL_LIMIT   = 20000;
   localparam int         RANDOM_ITEMS  = 800;
   localparam int         REPORT_MAX    = 10;

   typedef struct packed {
      event_type           ev;
      logic [COORD_W-1:0]  col;
      logic [COORD_W-1:0]  row;
      logic [DEPTH_W-1:0]  depth;
   } maze_event_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_operation;
   logic [COORD_W-1:0]   req_cell_col;
   logic [COORD_W-1:0]   req_cell_row;
   logic                 req_wall_north;
   logic                 req_wall_east;
   logic                 req_wall_south;
   logic                 req_wall_west;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [2:0]           rsp_event_res;
   logic [COORD_W-1:0]   rsp_event_col;
   logic [COORD_W-1:0]   rsp_event_row;
   logic [DEPTH_W-1:0]   rsp_stack_depth;
   logic                 csr_valid;
   logic                 csr_ready;
   logic                 csr_index;
   logic [GRID_W-1:0]    csr_wdata;

   grid_maze_dfs_solver DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_cell_col    (req_cell_col),
      .req_cell_row    (req_cell_row),
      .req_wall_north  (req_wall_north),
      .req_wall_east   (req_wall_east),
      .req_wall_south  (req_wall_south),
      .req_wall_west   (req_wall_west),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_res   (rsp_event_res),
      .rsp_event_col   (rsp_event_col),
      .rsp_event_row   (rsp_event_row),
      .rsp_stack_depth (rsp_stack_depth),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5ns clock = ~clock;

   // shared run state
   maze_event_type  pending_events[$];
   int           fail_count;
   int           items_sent;
   bit           idle_on;
   int           drain_hold_cycles;
   int           stall_cycles;

   // solver shadow state
   logic [WALL_W-1:0]   wall_mem [CELLS];
   bit [CELLS-1:0]      wall_written;
   bit [CELLS-1:0]      seen_cell;
   logic [COORD_W-1:0]  trail_col [CELLS];
   logic [COORD_W-1:0]  trail_row [CELLS];
   int unsigned         trail_len;
   status_type          search_phase;
   logic [GRID_W-1:0]   cols_reg;
   logic [GRID_W-1:0]   rows_reg;

   function automatic int unsigned cell_at(input logic [COORD_W-1:0] col,
                                           input logic [COORD_W-1:0] row);
      return int'(row) * MAX_COLS + int'(col);
   endfunction

   // size register as the grid actually uses it
   function automatic int unsigned grid_span(input logic [GRID_W-1:0] v, input int unsigned top);
      if (v < MIN_GRID) begin
         return MIN_GRID;
      end
      if (v > top) begin
         return top;
      end
      return v;
   endfunction

   function automatic bit is_goal_cell(input logic [COORD_W-1:0] col,
                                       input logic [COORD_W-1:0] row);
      return (col == grid_span(cols_reg, MAX_COLS) / 2 - 1) &&
             (row == grid_span(rows_reg, MAX_ROWS) / 2 - 1);
   endfunction

   // push a cell onto the search path and mark it seen
   function automatic maze_event_type push_trail(input logic [COORD_W-1:0] col,
                                                 input logic [COORD_W-1:0] row);
      maze_event_type ev;
      if (trail_len < CELLS) begin
         trail_col[trail_len] = col;
         trail_row[trail_len] = row;
         trail_len++;
      end
      seen_cell[cell_at(col, row)] = 1'b1;
      ev.col = col;
      ev.row = row;
      ev.depth = '0;
      if (is_goal_cell(col, row)) begin
         search_phase = ST_GOAL;
         ev.ev = EV_GOAL;
      end else begin
         ev.ev = EV_VISITED;
      end
      return ev;
   endfunction

   // model of the solver for one item: returns the event this item causes
   function automatic maze_event_type solver_predict(input logic [1:0] op,
                                                     input logic [COORD_W-1:0] col,
                                                     input logic [COORD_W-1:0] row,
                                                     input logic [WALL_W-1:0] walls);
      maze_event_type ev;
      logic [COORD_W-1:0] tc, tr, nc, nr;
      logic [WALL_W-1:0] w;
      int unsigned ncols, nrows, t;
      bit in_grid, found;
      ev.ev = EV_IDLE;
      ev.col = '0;
      ev.row = '0;
      ev.depth = '0;
      found = 1'b0;
      case (op)
         OP_LOAD: begin
            wall_mem[cell_at(col, row)] = walls;
            wall_written[cell_at(col, row)] = 1'b1;
            ev.ev = EV_LOADED;
            ev.col = col;
            ev.row = row;
         end
         OP_START: begin
            seen_cell = '0;
            trail_len = 0;
            search_phase = ST_SEARCH;
            ev = push_trail('0, '0);
         end
         OP_ADVANCE: begin
            if (search_phase == ST_IDLE) begin
               ev.ev = EV_IDLE;
            end else if (search_phase == ST_GOAL) begin
               t = (trail_len != 0) ? trail_len - 1 : 0;
               ev.ev = EV_GOAL;
               ev.col = trail_col[t];
               ev.row = trail_row[t];
            end else if (search_phase == ST_FAIL || trail_len == 0) begin
               search_phase = ST_FAIL;
               ev.ev = EV_NOPATH;
            end else begin
               tc = trail_col[trail_len - 1];
               tr = trail_row[trail_len - 1];
               w = wall_mem[cell_at(tc, tr)];
               ncols = grid_span(cols_reg, MAX_COLS);
               nrows = grid_span(rows_reg, MAX_ROWS);
               // neighbours north, east, south, west; grid edge counts as a wall
               for (int d = 0; d < 4 && !found; d++) begin
                  nc = tc;
                  nr = tr;
                  case (dir_type'(d))
                     DIR_N: begin
                        in_grid = (tr + 1) < nrows;
                        nr = tr + 1;
                     end
                     DIR_E: begin
                        in_grid = (tc + 1) < ncols;
                        nc = tc + 1;
                     end
                     DIR_S: begin
                        in_grid = tr > 0;
                        nr = tr - 1;
                     end
                     default: begin
                        in_grid = tc > 0;
                        nc = tc - 1;
                     end
                  endcase
                  if (!w[d] && in_grid && !seen_cell[cell_at(nc, nr)]) begin
                     found = 1'b1;
                     ev = push_trail(nc, nr);
                  end
               end
               // dead end: back up one cell
               if (!found) begin
                  trail_len--;
                  ev.ev = EV_ABANDONED;
                  ev.col = tc;
                  ev.row = tr;
               end
            end
         end
         default: begin
            ev.ev = EV_IDLE;
         end
      endcase
      ev.depth = trail_len[DEPTH_W-1:0];
      return ev;
   endfunction

   function automatic logic [WALL_W-1:0] draw_walls(input int density);
      logic [WALL_W-1:0] w;
      for (int b = 0; b < WALL_W; b++) begin
         w[b] = $urandom_range(0, 3) < density;
      end
      return w;
   endfunction

   function automatic logic [GRID_W-1:0] draw_size();
      case ($urandom_range(0, 9))
         0: return GRID_W'($urandom_range(0, 1));
         1: return GRID_W'($urandom_range(33, 63));
         2: return GRID_W'(32);
         default: return GRID_W'($urandom_range(2, 6));
      endcase
   endfunction

   // offer one item and record what it should produce once accepted
   task automatic send_item(input logic [1:0] op, input logic [COORD_W-1:0] col,
                            input logic [COORD_W-1:0] row, input logic [WALL_W-1:0] walls);
      int gap;
      maze_event_type predicted;
      gap = idle_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_cell_col <= col;
      req_cell_row <= row;
      req_wall_north <= walls[DIR_N];
      req_wall_east <= walls[DIR_E];
      req_wall_south <= walls[DIR_S];
      req_wall_west <= walls[DIR_W];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = solver_predict(op, col, row, walls);
      pending_events.push_back(predicted);
      items_sent++;
   endtask

   task automatic send_load(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                            input logic [WALL_W-1:0] walls);
      send_item(OP_LOAD, col, row, walls);
   endtask

   // unused fields carry random bits
   task automatic send_plain(input logic [1:0] op);
      send_item(op, COORD_W'($urandom), COORD_W'($urandom), WALL_W'($urandom));
   endtask

   // advance, loading the top cell first if its walls were never written
   task automatic send_advance();
      logic [COORD_W-1:0] tc, tr;
      if (search_phase == ST_SEARCH && trail_len != 0) begin
         tc = trail_col[trail_len - 1];
         tr = trail_row[trail_len - 1];
         if (!wall_written[cell_at(tc, tr)]) begin
            send_load(tc, tr, WALL_W'($urandom));
         end
      end
      send_plain(OP_ADVANCE);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_events.size() != 0);
   endtask

   // write both size registers, in random order
   task automatic set_grid(input logic [GRID_W-1:0] cols, input logic [GRID_W-1:0] rows);
      bit rows_first;
      logic idx;
      rows_first = $urandom_range(0, 1);
      for (int k = 0; k < 2; k++) begin
         idx = ((k == 0) != rows_first) ? REG_GRID_COLS : REG_GRID_ROWS;
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= (idx == REG_GRID_COLS) ? cols : rows;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         if (idx == REG_GRID_COLS) begin
            cols_reg = cols;
         end else begin
            rows_reg = rows;
         end
      end
      csr_valid <= 1'b0;
   endtask

   // hand-picked items: idle advance, unknown op, start on goal, dead end, edges
   task automatic test_directed();
      idle_on = 1'b1;
      send_advance();
      send_plain(OP_UNKNOWN);
      send_load(5'd31, 5'd31, 4'b1111);
      send_load(5'd0, 5'd0, 4'b1111);
      // sizes below the minimum clamp to 2 x 2, so the start cell is the goal
      wait_drained();
      set_grid(6'd0, 6'd1);
      send_plain(OP_START);
      send_advance();
      // walled-in start cell: abandon, then no path twice
      wait_drained();
      set_grid(6'd63, 6'd4);
      send_plain(OP_START);
      send_advance();
      send_advance();
      send_advance();
      send_plain(OP_UNKNOWN);
      // 4 x 2 grid: north, east past the top edge, south into the goal
      wait_drained();
      set_grid(6'd4, 6'd2);
      send_load(5'd0, 5'd0, 4'b0000);
      send_load(5'd0, 5'd1, 4'b0000);
      send_load(5'd1, 5'd1, 4'b0010);
      send_plain(OP_START);
      send_advance();
      send_advance();
      send_advance();
      send_advance();
      send_plain(OP_START);
   endtask

   // receiver holds off long while items keep coming, then sender drains
   task automatic test_backpressure();
      wait_drained();
      idle_on = 1'b0;
      drain_hold_cycles = 400;
      for (int k = 0; k < 12; k++) begin
         case (k % 3)
            0: send_plain(OP_UNKNOWN);
            1: send_load(COORD_W'($urandom), COORD_W'($urandom), WALL_W'($urandom));
            default: send_advance();
         endcase
      end
      wait_drained();
   endtask

   // random mazes: mostly well-formed searches, some noise and resized grids
   task automatic test_random_mazes();
      int target, density, ncols, nrows, steps, cap, pick;
      bit resume;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         wait_drained();
         set_grid(draw_size(), draw_size());
         idle_on = $urandom_range(0, 3) != 0;
         density = $urandom_range(0, 3);
         ncols = grid_span(cols_reg, MAX_COLS);
         nrows = grid_span(rows_reg, MAX_ROWS);
         resume = $urandom_range(0, 4) == 0;
         if (!resume) begin
            if (ncols * nrows <= 64 && $urandom_range(0, 4) != 0) begin
               for (int r = 0; r < nrows; r++) begin
                  for (int c = 0; c < ncols; c++) begin
                     send_load(COORD_W'(c), COORD_W'(r), draw_walls(density));
                  end
               end
            end
            send_plain(OP_START);
         end
         cap = (2 * ncols * nrows + 4 < 120) ? 2 * ncols * nrows + 4 : 120;
         steps = 0;
         while (search_phase == ST_SEARCH && steps < cap) begin
            pick = $urandom_range(0, 19);
            case (pick)
               0: send_plain(OP_UNKNOWN);
               1: send_load(COORD_W'($urandom), COORD_W'($urandom), WALL_W'($urandom));
               2: send_plain(OP_START);
               default: send_advance();
            endcase
            steps++;
         end
         // extra advances: repeats after goal or failure, else further search steps
         repeat ($urandom_range(0, 2)) send_advance();
      end
   endtask

   // result side: random ready gaps, long hold on request
   initial begin : result_side
      int gap;
      maze_event_type exp_ev;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (drain_hold_cycles > 0) begin
            gap = drain_hold_cycles;
            drain_hold_cycles = 0;
         end else begin
            gap = idle_on ? $urandom_range(0, 14) : 0;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         // compare with the oldest expected item
         if (pending_events.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
               $display("unexpected result ev=%0d col=%0d row=%0d depth=%0d",
                        rsp_event_res, rsp_event_col, rsp_event_row, rsp_stack_depth);
            end
         end else begin
            exp_ev = pending_events.pop_front();
            if (rsp_event_res !== exp_ev.ev || rsp_event_col !== exp_ev.col ||
                rsp_event_row !== exp_ev.row || rsp_stack_depth !== exp_ev.depth) begin
               fail_count++;
               if (fail_count <= REPORT_MAX) begin
                  $display("mismatch: exp ev=%0d col=%0d row=%0d depth=%0d, got ev=%0d col=%0d row=%0d depth=%0d",
                           exp_ev.ev, exp_ev.col, exp_ev.row, exp_ev.depth,
                           rsp_event_res, rsp_event_col, rsp_event_row, rsp_stack_depth);
               end
            end
         end
      end
   end

   // stall watchdog: cycles with no item accepted on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // reset, tests in turn, verdict
   initial begin
      fail_count = 0;
      items_sent = 0;
      idle_on = 1'b0;
      drain_hold_cycles = 0;
      wall_written = '0;
      seen_cell = '0;
      trail_len = 0;
      search_phase = ST_IDLE;
      cols_reg = GRID_W'(MAX_COLS);
      rows_reg = GRID_W'(MAX_ROWS);
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= OP_LOAD;
      req_cell_col <= '0;
      req_cell_row <= '0;
      req_wall_north <= 1'b0;
      req_wall_east <= 1'b0;
      req_wall_south <= 1'b0;
      req_wall_west <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= REG_GRID_COLS;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_mazes();
      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_events.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/gmds_pkg.sv
rtl/core/gmds_cell_mem.sv
rtl/core/gmds_stack_mem.sv
rtl/core/gmds_ctrl.sv
rtl/core/grid_maze_dfs_solver.sv
verif/tb_top.sv
